FILE: hw/rtl/ecw_pkg.sv
package ecw_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int STACK_DEPTH  = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int KW           = $clog2(RESULT_LIMIT + 1);

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_RUN   = 1'b1;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_CIRCUIT = 2'd1;
  localparam logic [1:0] VERDICT_PATH    = 2'd2;

  localparam logic [3:0] VCOUNT_RESET = 4'd8;

  typedef struct packed {
    logic ready;
    logic class_step;
    logic copy;
    logic emit_none;
    logic push;
    logic pop;
    logic refill;
  } cmd_t;

  typedef struct packed {
    logic run_go;
    logic class_last;
    logic verdict_none;
    logic out_free;
    logic has_nb;
    logic pop_last;
  } stat_t;

endpackage

FILE: hw/rtl/ecw_if.sv
interface ecw_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] row;
  logic [2:0] col;
  logic       edge_present;
  logic [2:0] start_vertex;

  modport source (output valid, command, row, col, edge_present, start_vertex, input ready);
  modport sink   (input valid, command, row, col, edge_present, start_vertex, output ready);
endinterface

interface ecw_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] vertex;
  logic       vertex_valid;
  logic [1:0] verdict;
  logic       last;

  modport source (output valid, vertex, vertex_valid, verdict, last, input ready);
  modport sink   (input valid, vertex, vertex_valid, verdict, last, output ready);
endinterface

FILE: hw/rtl/ecw_ram.sv
module ecw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ecw_datapath.sv
module ecw_datapath #(
  parameter int MAX_VERTICES = ecw_pkg::MAX_VERTICES,
  parameter int STACK_DEPTH  = ecw_pkg::STACK_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  ecw_req_if.sink        req,
  ecw_rsp_if.source      rsp,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_wdata,
  input  ecw_pkg::cmd_t  cmd,
  output ecw_pkg::stat_t st
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int KW = ecw_pkg::KW;

  logic [3:0]              vcount;
  logic [MAX_VERTICES-1:0] adj  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] work [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reach;
  logic [1:0]              odd;
  logic [VW-1:0]           idx;
  logic [VW-1:0]           start_q;
  logic [1:0]              verdict_q;
  logic [VW-1:0]           top;
  logic [SW-1:0]           sp;
  logic [KW-1:0]           kcnt;

  logic [NW-1:0]           n;
  logic [MAX_VERTICES-1:0] mask;
  logic [MAX_VERTICES-1:0] reach_or;
  logic                    row_par;
  logic                    connected;
  logic [1:0]              verdict_c;
  logic [MAX_VERTICES-1:0] cur_row;
  logic [VW-1:0]           nb;
  logic [VW+2:0]           rowx, colx, startx, topx;
  logic                    acc;
  logic [VW-1:0]           rdata;

  assign acc    = req.valid && req.ready;
  assign rowx   = (VW+3)'(req.row);
  assign colx   = (VW+3)'(req.col);
  assign startx = (VW+3)'(req.start_vertex);
  assign topx   = (VW+3)'(top);

  always_comb begin
    if (vcount == 4'd0) begin
      n = NW'(1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vcount);
    end
  end

  always_comb begin
    mask     = '0;
    reach_or = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (i < int'(n));
    end
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (reach[j]) begin
        reach_or = reach_or | (adj[j] & mask);
      end
    end
  end

  assign row_par   = ^(adj[idx] & mask);
  assign connected = ((reach & mask) == mask);

  always_comb begin
    if (!connected) begin
      verdict_c = ecw_pkg::VERDICT_NONE;
    end else if (odd == 2'd0) begin
      verdict_c = ecw_pkg::VERDICT_CIRCUIT;
    end else if (odd == 2'd2) begin
      verdict_c = ecw_pkg::VERDICT_PATH;
    end else begin
      verdict_c = ecw_pkg::VERDICT_NONE;
    end
  end

  // lowest-numbered neighbour of the top vertex
  assign cur_row = work[top];
  always_comb begin
    nb = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cur_row[i]) begin
        nb = VW'(i);
      end
    end
  end

  assign st.run_go       = acc && (req.command == ecw_pkg::CMD_RUN);
  assign st.class_last   = (NW'(idx) == n - NW'(1));
  assign st.verdict_none = (verdict_c == ecw_pkg::VERDICT_NONE);
  assign st.out_free     = !rsp.valid || rsp.ready;
  assign st.has_nb       = (|cur_row) && (sp < SW'(STACK_DEPTH));
  assign st.pop_last     = (sp == SW'(1)) || (kcnt == KW'(ecw_pkg::RESULT_LIMIT - 1));

  assign req.ready = cmd.ready;

  ecw_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (AW'(sp - SW'(1))),
    .wdata (top),
    .raddr (AW'(sp - SW'(2))),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= ecw_pkg::VCOUNT_RESET;
      rsp.valid <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (acc && req.command == ecw_pkg::CMD_WRITE &&
          int'(req.row) < MAX_VERTICES && int'(req.col) < MAX_VERTICES) begin
        adj[rowx[VW-1:0]][colx[VW-1:0]] <= req.edge_present;
      end
      if (cmd.pop || cmd.emit_none) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end

    if (st.run_go) begin
      reach   <= MAX_VERTICES'(1);
      odd     <= 2'd0;
      idx     <= '0;
      start_q <= (int'(req.start_vertex) < int'(n)) ? startx[VW-1:0] : '0;
    end
    if (cmd.class_step) begin
      reach <= reach | reach_or;
      idx   <= idx + VW'(1);
      if (row_par && odd != 2'd3) begin
        odd <= odd + 2'd1;
      end
    end
    if (cmd.copy) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        work[i] <= (i < int'(n)) ? (adj[i] & mask) : '0;
      end
      top       <= start_q;
      sp        <= SW'(1);
      kcnt      <= '0;
      verdict_q <= verdict_c;
    end
    if (cmd.push) begin
      work[top][nb] <= 1'b0;
      work[nb][top] <= 1'b0;
      top           <= nb;
      sp            <= sp + SW'(1);
    end
    if (cmd.pop) begin
      rsp.vertex       <= topx[2:0];
      rsp.vertex_valid <= 1'b1;
      rsp.verdict      <= verdict_q;
      rsp.last         <= st.pop_last;
      sp               <= sp - SW'(1);
      kcnt             <= kcnt + KW'(1);
    end
    if (cmd.refill) begin
      top <= rdata;
    end
    if (cmd.emit_none) begin
      rsp.vertex       <= 3'd0;
      rsp.vertex_valid <= 1'b0;
      rsp.verdict      <= ecw_pkg::VERDICT_NONE;
      rsp.last         <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/ecw_ctrl.sv
module ecw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  ecw_pkg::stat_t st,
  output ecw_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_DECIDE,
    S_WALK,
    S_REFILL
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.ready      = (state == S_IDLE);
    cmd.class_step = (state == S_CLASS);
    cmd.copy       = (state == S_DECIDE) && !st.verdict_none;
    cmd.emit_none  = (state == S_DECIDE) && st.verdict_none && st.out_free;
    cmd.push       = (state == S_WALK) && st.has_nb;
    cmd.pop        = (state == S_WALK) && !st.has_nb && st.out_free;
    cmd.refill     = (state == S_REFILL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (st.run_go) state <= S_CLASS;
        end
        S_CLASS: begin
          if (st.class_last) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!st.verdict_none) begin
            state <= S_WALK;
          end else if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (!st.has_nb && st.out_free) begin
            state <= st.pop_last ? S_IDLE : S_REFILL;
          end
        end
        S_REFILL: state <= S_WALK;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/euler_circuit_walker_top.sv
// Euler circuit / path walker over an adjacency bit matrix of up to MAX_VERTICES
// vertices. A write transaction (command 0) stores one matrix entry and gives no
// result; the mirror entry is not touched. A run transaction (command 1) first
// classifies the graph over the first vertex_count vertices (0 is taken as 1, and
// at most MAX_VERTICES are used), one step per vertex in use, each step widening
// the set reached from vertex 0 and folding in the degree parity of one row. If
// the graph is not a circuit or path, one result transaction with vertex_valid
// low and last high follows. Otherwise a working copy is loaded and the stack
// walk runs: each step either pushes a neighbour of the top vertex, or pops the
// top vertex and then refills the top of stack from the walk stack, a RAM with
// registered read; a pop waits while the result side stalls. Each popped vertex
// leaves as one result transaction, the final one with last high. The input
// side is not ready while a run is in progress.
module euler_circuit_walker_top #(
  parameter int MAX_VERTICES = ecw_pkg::MAX_VERTICES,
  parameter int STACK_DEPTH  = ecw_pkg::STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  ecw_req_if.sink    req,
  ecw_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  // command and status between sequencer and datapath
  ecw_pkg::cmd_t  cmd;
  ecw_pkg::stat_t st;

  ecw_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  ecw_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

  // a result without a vertex is always the single verdict-none transaction
  a_none_item: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.vertex_valid |-> rsp.last && rsp.verdict == ecw_pkg::VERDICT_NONE)
    else $error("vertexless result is not a lone none verdict");

  // walk vertices only come from circuit or path runs
  a_walk_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.vertex_valid |->
      rsp.verdict == ecw_pkg::VERDICT_CIRCUIT || rsp.verdict == ecw_pkg::VERDICT_PATH)
    else $error("walk vertex with none verdict");

  // a run transaction closes the input side on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == ecw_pkg::CMD_RUN |=> !req.ready)
    else $error("input ready right after a run transaction");

endmodule
